// ===== hdl/qetok_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qetok_pkg
// Shared types, codes and helpers of the quoted, escaped string tokenizer.
// ----------------------------------------------------------------------------
package qetok_pkg;

  localparam int unsigned MAX_SET_CHARS = 8;
  localparam int unsigned SET_W         = 64;
  localparam int unsigned CNT_W         = 4;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESERVE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZES    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEPQ    = 3'd5;

  // reset values of the registers
  localparam logic [SET_W-1:0] RST_DELIM    = 64'h0920;
  localparam logic [SET_W-1:0] RST_PRESERVE = 64'h0;
  localparam logic [SET_W-1:0] RST_QUOTE    = 64'h2722;
  localparam logic [SET_W-1:0] RST_ESCAPE   = 64'h005C;
  localparam logic [15:0]      RST_SIZES    = 16'h1202;

  // result kinds
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_DELIM  = 2'd2;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
  } res_t;

  // one queue entry: the one or two results of a request
  typedef struct packed {
    logic two;
    res_t res0;
    res_t res1;
  } q_entry_t;

  // byte lookup in a packed set; counts above the limit saturate
  function automatic logic in_set(input logic [SET_W-1:0] set,
                                  input logic [CNT_W-1:0] cnt,
                                  input logic [7:0]       ch);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < MAX_SET_CHARS; i++) begin
      if ((CNT_W'(i) < cnt) && (set[8*i +: 8] == ch)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/quoted_escaped_tokenizer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quoted_escaped_tokenizer_core
// Byte-serial tokenizer with quoting, escapes, plain and preserved delimiters.
// ----------------------------------------------------------------------------
// One byte is taken per request and classified in the cycle it is accepted;
// its results (none, one or two) go into a two-entry queue and leave through
// a registered output, one result per cycle while out_ready is high, so a
// new byte can be accepted every cycle while the queue has room and earlier
// results drain. The single output port sets the sustained rate, lower for
// bytes that yield two results. A byte's results wait in the queue, then go
// through the output register. Registers are written through cfg_* at any
// idle time and take effect on the next byte; indexes above five are ignored.
// ----------------------------------------------------------------------------
module quoted_escaped_tokenizer_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [qetok_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [qetok_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire qetok_pkg::in_item_t               in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output qetok_pkg::out_item_t                   out_data
);

  logic                push, q_full, pop, q_valid;
  qetok_pkg::q_entry_t push_data, q_data;

  qetok_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  qetok_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  qetok_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== hdl/qetok_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qetok_front
// Configuration registers, tokenizer state and byte classification. Each
// request with results gives one queue entry holding its one or two results.
// ----------------------------------------------------------------------------
module qetok_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [qetok_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [qetok_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire qetok_pkg::in_item_t               in_data,
  output logic                                   push,
  output qetok_pkg::q_entry_t                    push_data,
  input  wire logic                              q_full
);

  logic [qetok_pkg::SET_W-1:0] delim_r, preserve_r, quote_r, escape_r;
  logic [15:0]                 sizes_r;
  logic                        keepq_r;

  logic       in_quote_r, in_quote_nxt;
  logic [7:0] open_q_r, open_q_nxt;
  logic       esc_pend_r, esc_pend_nxt;
  logic       tok_ne_r, tok_ne_nxt;

  logic       accept;
  logic [1:0] cnt;
  logic       append, end_tok, delim_tok;
  logic [7:0] ch;
  qetok_pkg::res_t r0, r1, rx;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign ch       = in_data.char_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r    <= qetok_pkg::RST_DELIM;
      preserve_r <= qetok_pkg::RST_PRESERVE;
      quote_r    <= qetok_pkg::RST_QUOTE;
      escape_r   <= qetok_pkg::RST_ESCAPE;
      sizes_r    <= qetok_pkg::RST_SIZES;
      keepq_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qetok_pkg::CFG_DELIM:    delim_r    <= cfg_wdata;
        qetok_pkg::CFG_PRESERVE: preserve_r <= cfg_wdata;
        qetok_pkg::CFG_QUOTE:    quote_r    <= cfg_wdata;
        qetok_pkg::CFG_ESCAPE:   escape_r   <= cfg_wdata;
        qetok_pkg::CFG_SIZES:    sizes_r    <= cfg_wdata[15:0];
        qetok_pkg::CFG_KEEPQ:    keepq_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_quote_nxt = in_quote_r;
    open_q_nxt   = open_q_r;
    esc_pend_nxt = 1'b0;
    tok_ne_nxt   = tok_ne_r;
    append       = 1'b0;
    end_tok      = 1'b0;
    delim_tok    = 1'b0;

    if (esc_pend_r) begin
      append = 1'b1;
    end else if (qetok_pkg::in_set(escape_r, sizes_r[15:12], ch)) begin
      esc_pend_nxt = 1'b1;
    end else begin
      append = 1'b1;
      if (qetok_pkg::in_set(quote_r, sizes_r[11:8], ch)) begin
        if (!in_quote_r) begin
          in_quote_nxt = 1'b1;
          open_q_nxt   = ch;
          append       = keepq_r;
        end else if (open_q_r == ch) begin
          in_quote_nxt = 1'b0;
          open_q_nxt   = 8'd0;
          append       = keepq_r;
        end
      end
      if (!in_quote_nxt) begin
        if (qetok_pkg::in_set(delim_r, sizes_r[3:0], ch)) begin
          end_tok = 1'b1;
          append  = 1'b0;
        end
        if (qetok_pkg::in_set(preserve_r, sizes_r[7:4], ch)) begin
          if (tok_ne_r) end_tok = 1'b1;
          append    = 1'b0;
          delim_tok = 1'b1;
        end
      end
    end

    // place results in order; at most two can arise
    cnt = 2'd0;
    r0  = '0;
    r1  = '0;
    rx  = '0;
    if (append) begin
      r0         = '{kind: qetok_pkg::KIND_APPEND, char_out: ch};
      cnt        = 2'd1;
      tok_ne_nxt = 1'b1;
    end
    if (end_tok) begin
      rx = '{kind: qetok_pkg::KIND_END, char_out: 8'd0};
      if (cnt == 2'd0) r0 = rx;
      else             r1 = rx;
      cnt        = cnt + 2'd1;
      tok_ne_nxt = 1'b0;
    end
    if (delim_tok) begin
      rx = '{kind: qetok_pkg::KIND_DELIM, char_out: ch};
      if (cnt == 2'd0) r0 = rx;
      else             r1 = rx;
      cnt = cnt + 2'd1;
    end
    if (in_data.end_of_string) begin
      if (tok_ne_nxt) begin
        rx = '{kind: qetok_pkg::KIND_END, char_out: 8'd0};
        if (cnt == 2'd0) r0 = rx;
        else             r1 = rx;
        cnt = cnt + 2'd1;
      end
      in_quote_nxt = 1'b0;
      open_q_nxt   = 8'd0;
      esc_pend_nxt = 1'b0;
      tok_ne_nxt   = 1'b0;
    end

    push      = accept && (cnt != 2'd0);
    push_data = '{two: (cnt == 2'd2), res0: r0, res1: r1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quote_r <= 1'b0;
      open_q_r   <= 8'd0;
      esc_pend_r <= 1'b0;
      tok_ne_r   <= 1'b0;
    end else if (accept) begin
      in_quote_r <= in_quote_nxt;
      open_q_r   <= open_q_nxt;
      esc_pend_r <= esc_pend_nxt;
      tok_ne_r   <= tok_ne_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/qetok_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qetok_queue
// Two-entry queue between the classifier and the result serialiser.
// ----------------------------------------------------------------------------
module qetok_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire qetok_pkg::q_entry_t  push_data,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      q_valid,
  output qetok_pkg::q_entry_t       q_data
);

  qetok_pkg::q_entry_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/qetok_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qetok_back
// Result serialiser: sends queue results through the output register, one
// per cycle unless out_ready stalls, marking the last of each request.
// ----------------------------------------------------------------------------
module qetok_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  wire qetok_pkg::q_entry_t  q_data,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output qetok_pkg::out_item_t      out_data
);

  logic                 out_valid_r;
  qetok_pkg::out_item_t out_data_r;
  logic                 pend_valid_r;
  qetok_pkg::res_t      pend_r;
  logic                 load;

  assign load      = !out_valid_r || out_ready;
  assign pop       = load && !pend_valid_r && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (load) begin
      if (pend_valid_r) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= q_valid;
        pend_valid_r <= q_valid && q_data.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid_r) begin
        out_data_r <= '{kind: pend_r.kind, char_out: pend_r.char_out, last_of_run: 1'b1};
      end else begin
        out_data_r <= '{kind: q_data.res0.kind, char_out: q_data.res0.char_out,
                        last_of_run: !q_data.two};
        pend_r     <= q_data.res1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for quoted_escaped_tokenizer_core: bytes are sent with
// random gaps and the results are back-pressured at random. A tokenizer model
// in the bench predicts every result, which is compared field by field.
// ----------------------------------------------------------------------------
module tb;

  // indexes past the last register; writes to them must change nothing
  localparam logic [qetok_pkg::CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
  localparam logic [qetok_pkg::CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             cfg_we    = 1'b0;
  logic [qetok_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [qetok_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  qetok_pkg::in_item_t              in_data   = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  qetok_pkg::out_item_t             out_data;

  quoted_escaped_tokenizer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tokenizer model: configuration and state
  logic [63:0] tk_delim, tk_preserve, tk_quote, tk_escape;
  logic [15:0] tk_sizes;
  logic        tk_keepq;
  logic        tk_in_quote;
  logic [7:0]  tk_open_q;
  logic        tk_esc_pend;
  logic        tk_nonempty;

  qetok_pkg::out_item_t token_results[$];
  int        n_fail   = 0;
  int        idle_pct = 0;   // chance, in percent, of an idle burst on either side

  function automatic logic byte_in_set(input logic [63:0] set, input logic [3:0] cnt,
                                       input logic [7:0] ch);
    int  lim;
    logic hit;
    lim = (cnt > 4'd8) ? 8 : int'(cnt);
    hit = 1'b0;
    for (int i = 0; i < lim; i++)
      if (set[8*i +: 8] == ch) hit = 1'b1;
    return hit;
  endfunction

  task automatic reset_tokenizer();
    tk_delim    = qetok_pkg::RST_DELIM;
    tk_preserve = qetok_pkg::RST_PRESERVE;
    tk_quote    = qetok_pkg::RST_QUOTE;
    tk_escape   = qetok_pkg::RST_ESCAPE;
    tk_sizes    = qetok_pkg::RST_SIZES;
    tk_keepq    = 1'b0;
    tk_in_quote = 1'b0;
    tk_open_q   = '0;
    tk_esc_pend = 1'b0;
    tk_nonempty = 1'b0;
  endtask

  // works out the results of one byte and queues them
  task automatic tokenize_byte(input logic [7:0] ch, input logic eos);
    qetok_pkg::out_item_t res [3];
    int        n;
    logic      app, end_tok, dtok;
    n = 0; app = 1'b0; end_tok = 1'b0; dtok = 1'b0;
    if (tk_esc_pend) begin
      tk_esc_pend = 1'b0;
      app = 1'b1;
    end else if (byte_in_set(tk_escape, tk_sizes[15:12], ch)) begin
      tk_esc_pend = 1'b1;
    end else begin
      app = 1'b1;
      if (byte_in_set(tk_quote, tk_sizes[11:8], ch)) begin
        if (!tk_in_quote) begin
          tk_in_quote = 1'b1;
          tk_open_q   = ch;
          app         = tk_keepq;
        end else if (tk_open_q == ch) begin
          tk_in_quote = 1'b0;
          tk_open_q   = '0;
          app         = tk_keepq;
        end
      end
      if (!tk_in_quote) begin
        if (byte_in_set(tk_delim, tk_sizes[3:0], ch)) begin
          end_tok = 1'b1;
          app     = 1'b0;
        end
        if (byte_in_set(tk_preserve, tk_sizes[7:4], ch)) begin
          if (tk_nonempty) end_tok = 1'b1;
          app  = 1'b0;
          dtok = 1'b1;
        end
      end
    end
    if (app) begin
      res[n] = '{kind: qetok_pkg::KIND_APPEND, char_out: ch, last_of_run: 1'b0};
      n++;
      tk_nonempty = 1'b1;
    end
    if (end_tok) begin
      res[n] = '{kind: qetok_pkg::KIND_END, char_out: 8'h00, last_of_run: 1'b0};
      n++;
      tk_nonempty = 1'b0;
    end
    if (dtok) begin
      res[n] = '{kind: qetok_pkg::KIND_DELIM, char_out: ch, last_of_run: 1'b0};
      n++;
    end
    if (eos) begin
      if (tk_nonempty) begin
        res[n] = '{kind: qetok_pkg::KIND_END, char_out: 8'h00, last_of_run: 1'b0};
        n++;
      end
      tk_in_quote = 1'b0;
      tk_open_q   = '0;
      tk_esc_pend = 1'b0;
      tk_nonempty = 1'b0;
    end
    if (n > 0) res[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) token_results.insert(token_results.size(), res[i]);
  endtask

  task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
    if (n_fail < 40) $error("%s mismatch: expected %0h, got %0h", what, want, got);
    n_fail++;
  endtask

  // one process follows every handshake: register writes, requests, results
  always @(posedge clk) begin
    qetok_pkg::out_item_t want;
    if (!rst_n) begin
      reset_tokenizer();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          qetok_pkg::CFG_DELIM:    tk_delim    = cfg_wdata;
          qetok_pkg::CFG_PRESERVE: tk_preserve = cfg_wdata;
          qetok_pkg::CFG_QUOTE:    tk_quote    = cfg_wdata;
          qetok_pkg::CFG_ESCAPE:   tk_escape   = cfg_wdata;
          qetok_pkg::CFG_SIZES:    tk_sizes    = cfg_wdata[15:0];
          qetok_pkg::CFG_KEEPQ:    tk_keepq    = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        tokenize_byte(in_data.char_in, in_data.end_of_string);
      if (out_valid && out_ready) begin
        if (token_results.size() == 0) begin
          if (n_fail < 40)
            $error("unexpected result: kind %0d char_out %0h last_of_run %0b",
                   out_data.kind, out_data.char_out, out_data.last_of_run);
          n_fail++;
        end else begin
          want = token_results.pop_front();
          if (out_data.kind !== want.kind)
            report("kind", 8'(want.kind), 8'(out_data.kind));
          if (out_data.char_out !== want.char_out)
            report("char_out", want.char_out, out_data.char_out);
          if (out_data.last_of_run !== want.last_of_run)
            report("last_of_run", 8'(want.last_of_run), 8'(out_data.last_of_run));
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_ready = 1'b0;
        hold = $urandom_range(0, 6);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // called at a falling edge, returns at a falling edge with the request taken
  task automatic send_byte(input logic [7:0] ch, input logic eos);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid              = 1'b1;
    in_data.char_in       = ch;
    in_data.end_of_string = eos;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], i == s.len() - 1);
  endtask

  // sender holds off until every queued result has come out
  task automatic wait_drained();
    while (token_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [qetok_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // sizes and keep flag go out with junk in the unused upper bits
  task automatic write_config(input logic [63:0] d, input logic [63:0] p,
                              input logic [63:0] q, input logic [63:0] e,
                              input logic [15:0] sizes, input logic keep);
    logic [63:0] junk;
    wait_drained();
    write_reg(qetok_pkg::CFG_DELIM, d);
    write_reg(qetok_pkg::CFG_PRESERVE, p);
    write_reg(qetok_pkg::CFG_QUOTE, q);
    write_reg(qetok_pkg::CFG_ESCAPE, e);
    junk = {$urandom(), $urandom()};
    junk[15:0] = sizes;
    write_reg(qetok_pkg::CFG_SIZES, junk);
    junk = {$urandom(), $urandom()};
    junk[0] = keep;
    write_reg(qetok_pkg::CFG_KEEPQ, junk);
    if ($urandom_range(0, 1) == 1)
      write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE6 : CFG_SPARE7,
                {$urandom(), $urandom()});
  endtask

  // bytes that tend to matter to a tokenizer, plus the odd random one
  function automatic logic [7:0] special_byte();
    case ($urandom_range(0, 11))
      0:       return 8'h20;  // space
      1:       return 8'h09;  // tab
      2:       return 8'h2C;  // comma
      3:       return 8'h3B;  // semicolon
      4:       return 8'h22;  // double quote
      5:       return 8'h27;  // single quote
      6:       return 8'h5C;  // backslash
      7:       return 8'h7C;  // bar
      8:       return 8'h00;
      9:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [63:0] rand_set();
    logic [63:0] s;
    if ($urandom_range(0, 4) == 0) return {$urandom(), $urandom()};
    for (int i = 0; i < 8; i++) s[8*i +: 8] = special_byte();
    return s;
  endfunction

  function automatic logic [15:0] rand_sizes();
    logic [15:0] s;
    for (int i = 0; i < 4; i++)
      s[4*i +: 4] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(1, 4));
    return s;
  endfunction

  // mostly bytes from the configured sets, so the quoting and escape paths get hit
  function automatic logic [7:0] pick_byte();
    logic [63:0] s;
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'($urandom_range(0, 255));
      3:       s = tk_delim;
      4:       s = tk_preserve;
      5:       s = tk_quote;
      6:       s = tk_escape;
      default: return 8'h61 + 8'($urandom_range(0, 2));
    endcase
    return s[8*$urandom_range(0, 7) +: 8];
  endfunction

  task automatic random_strings(input int n, input bit may_idle);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          2:       idle_pct = 30;
          default: idle_pct = 60;
        endcase
        if (!may_idle) idle_pct = 0;
      end
      send_byte(pick_byte(), $urandom_range(0, 9) == 0);
    end
  endtask

  // reset settings: plain and quoted runs, escapes, empty quotes, byte extremes
  task automatic test_reset_settings();
    idle_pct = 20;
    send_text("a  \"b c'\"");
    send_text("\\\\\\ \"\"\t");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5C, 1'b1);   // escape on the last byte is dropped
    send_text("'q");          // quote still open at end of string
  endtask

  // preserved delimiters, a byte in both delimiter sets, quotes kept
  task automatic test_preserve_keep();
    write_config(64'h2C20, 64'h3B2C, 64'h22, 64'h5C, 16'h1122, 1'b1);
    send_text("a;;,\";\"");
  endtask

  task automatic test_extreme_settings();
    write_config('1, '1, '1, '1, 16'hFFFF, 1'b1);
    random_strings(100, 1'b1);
    write_config('0, '0, '0, '0, 16'h0000, 1'b0);
    random_strings(60, 1'b1);
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 6; ph++) begin
      write_config(rand_set(), rand_set(), rand_set(), rand_set(), rand_sizes(),
                   1'($urandom_range(0, 1)));
      random_strings(220, 1'b1);
    end
  endtask

  task automatic test_full_rate();
    write_config(rand_set(), rand_set(), rand_set(), rand_set(), rand_sizes(),
                 1'($urandom_range(0, 1)));
    random_strings(270, 1'b0);
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_settings();
    test_preserve_keep();
    test_extreme_settings();
    test_random_settings();
    test_full_rate();
    idle_pct = 0;
    wait_drained();
    repeat (20) @(negedge clk);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
